>>> design/sct_pkg.sv
// Shared constants, codes, types and helpers for the sector cache tag manager.
package sct_pkg;

  // Sizing of the cache and of its metadata.
  localparam int ENTRIES  = 64;
  localparam int TAG_BITS = 32;
  localparam int PIN_BITS = 8;

  // Fixed field widths of the transaction payloads.
  localparam int FUNC_W   = 2;
  localparam int SECTOR_W = 32;
  localparam int EIDX_W   = 6;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;

  // Derived widths and limits.
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int STEP_W = $clog2(2 * ENTRIES);
  localparam int WORD_W = TAG_BITS + PIN_BITS + 1;

  localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [STEP_W-1:0]   STEP_LAST = STEP_W'(2 * ENTRIES - 1);
  localparam logic [PIN_BITS-1:0] PIN_MAX   = {PIN_BITS{1'b1}};
  localparam logic [PIN_BITS-1:0] PIN_ONE   = PIN_BITS'(1);

  // Request codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_LOOKUP  = 2'd0,
    FN_RELEASE = 2'd1,
    FN_FLUSH   = 2'd2
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT       = 3'd0,
    ST_FILL      = 3'd1,
    ST_EVICT     = 3'd2,
    ST_BUSY      = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_REL_UNDER = 3'd5,
    ST_FLUSHED   = 3'd6
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SWEEP,
    S_REL,
    S_FLUSH,
    S_FLRD,
    S_RESP
  } state_t;

  // One result as it travels from the controller to the output stage.
  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     slot;
    logic                  writeback;
    logic [SECTOR_W-1:0]   writeback_sector;
    logic                  fetch;
    logic                  last;
  } res_t;

  // Index of the next entry, wrapping at the end of the cache.
  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    nxt = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    return nxt;
  endfunction

  // Pack the fields of one result.
  function automatic res_t make_res(input status_t status, input logic [SLOT_W-1:0] slot,
                                    input logic wb, input logic [SECTOR_W-1:0] sector,
                                    input logic fetch, input logic last);
    res_t r;
    r.status           = status;
    r.slot             = slot;
    r.writeback        = wb;
    r.writeback_sector = sector;
    r.fetch            = fetch;
    r.last             = last;
    return r;
  endfunction

endpackage

>>> design/sct_if.sv
// Valid/ready channel interfaces for requests and results.
interface sct_in_if;
  import sct_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SECTOR_W-1:0] sector_number;
  logic [EIDX_W-1:0]   entry_index;

  modport source (output valid, func, sector_number, entry_index, input ready);
  modport sink   (input valid, func, sector_number, entry_index, output ready);
endinterface

interface sct_out_if;
  import sct_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic                writeback;
  logic [SECTOR_W-1:0] writeback_sector;
  logic                fetch;
  logic                last;

  modport source (output valid, status, slot, writeback, writeback_sector, fetch, last,
                  input ready);
  modport sink   (input valid, status, slot, writeback, writeback_sector, fetch, last,
                  output ready);
endinterface

>>> design/sector_cache_tags_with_clock_eviction_top.sv
// Lookup: the tag scan ends in a hit or fill result; a hit ends the scan at its entry.
// If all entries are valid a clock sweep follows; sweep and tag scan take one entry per cycle.
// Release reads and updates one entry; flush skips invalid entries and emits each valid one.
// One transaction is processed at a time; a new one is taken while a result waits.
// Synchronous active-low reset clears valid, pin and accessed state and the hand at once;
// the tag RAM is not cleared and needs no clearing pass.
module sector_cache_tags_with_clock_eviction_top (
  input  logic      clk,
  input  logic      rst_n,
  sct_in_if.sink    in_ch,
  sct_out_if.source out_ch
);
  import sct_pkg::*;

  logic              out_free;
  logic              emit_valid;
  res_t              emit;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // Entry RAM: tag, pin count and accessed bit of each entry.
  sct_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sct_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_func          (in_ch.func),
    .in_sector_number (in_ch.sector_number),
    .in_entry_index   (in_ch.entry_index),
    .out_free         (out_free),
    .emit_valid       (emit_valid),
    .emit             (emit),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  sct_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_valid (emit_valid),
    .emit       (emit),
    .free       (out_free),
    .out_ch     (out_ch)
  );

  // Only fills and evictions ask for a sector to be fetched.
  a_fetch_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.fetch |-> (out_ch.status == ST_FILL || out_ch.status == ST_EVICT))
    else $error("fetch on a result that is not a fill or an eviction");

  // Only evictions and flushes request a write-back.
  a_wb_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.writeback |->
      (out_ch.status == ST_EVICT || out_ch.status == ST_FLUSHED))
    else $error("write-back on a result that is not an eviction or a flush");

  // A busy result carries no slot and no side effects.
  a_busy_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_BUSY |->
      (out_ch.slot == '0 && !out_ch.writeback && !out_ch.fetch && out_ch.last))
    else $error("busy result with a slot, write-back or fetch");

  // An accepted lookup keeps the request side closed while the scan runs.
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.func == FN_LOOKUP |=> !in_ch.ready)
    else $error("request accepted during a tag scan");

endmodule

>>> design/sct_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/sct_ctrl.sv
// Request sequencer: tag scan, clock sweep, release and flush over the entry RAM.
module sct_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sct_pkg::FUNC_W-1:0]    in_func,
  input  logic [sct_pkg::SECTOR_W-1:0]  in_sector_number,
  input  logic [sct_pkg::EIDX_W-1:0]    in_entry_index,
  input  logic                          out_free,
  output logic                          emit_valid,
  output sct_pkg::res_t                 emit,
  output logic                          ram_we,
  output logic [sct_pkg::IDX_W-1:0]     ram_waddr,
  output logic [sct_pkg::WORD_W-1:0]    ram_wdata,
  output logic                          ram_re,
  output logic [sct_pkg::IDX_W-1:0]     ram_raddr,
  input  logic [sct_pkg::WORD_W-1:0]    ram_rdata
);
  import sct_pkg::*;

  state_t              state_r,     state_nxt;
  logic [IDX_W-1:0]    cnt_r,       cnt_nxt;
  logic [STEP_W-1:0]   step_r,      step_nxt;
  logic [IDX_W-1:0]    hand_r,      hand_nxt;
  logic [TAG_BITS-1:0] tag_r,       tag_nxt;
  logic                inv_found_r, inv_found_nxt;
  logic [IDX_W-1:0]    inv_idx_r,   inv_idx_nxt;
  logic [ENTRIES-1:0]  valid_r,     valid_nxt;
  logic [ENTRIES-1:0]  meta_ok_r,   meta_ok_nxt;
  res_t                pend_r,      pend_nxt;

  logic [IDX_W-1:0]    data_idx;
  logic [IDX_W-1:0]    fill_idx;
  logic [TAG_BITS-1:0] rd_tag;
  logic [PIN_BITS-1:0] rd_pins;
  logic                rd_acc;
  logic [PIN_BITS-1:0] pins_inc;

  // Decode the word that came back from the RAM. Pins and the accessed bit of
  // an entry never written since reset read as zero.
  assign data_idx = (state_r == S_SWEEP) ? hand_r : cnt_r;
  assign rd_tag   = ram_rdata[WORD_W-1:PIN_BITS+1];
  assign rd_pins  = meta_ok_r[data_idx] ? ram_rdata[PIN_BITS:1] : '0;
  assign rd_acc   = meta_ok_r[data_idx] & ram_rdata[0];
  assign pins_inc = (rd_pins == PIN_MAX) ? rd_pins : rd_pins + PIN_ONE;
  assign fill_idx = inv_found_r ? inv_idx_r : cnt_r;

  // State and metadata registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      hand_r    <= '0;
      valid_r   <= '0;
      meta_ok_r <= '0;
    end else begin
      state_r   <= state_nxt;
      hand_r    <= hand_nxt;
      valid_r   <= valid_nxt;
      meta_ok_r <= meta_ok_nxt;
    end
  end

  // Working registers of the transaction in progress.
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    step_r      <= step_nxt;
    tag_r       <= tag_nxt;
    inv_found_r <= inv_found_nxt;
    inv_idx_r   <= inv_idx_nxt;
    pend_r      <= pend_nxt;
  end

  // Next state and RAM control.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    hand_nxt      = hand_r;
    tag_nxt       = tag_r;
    inv_found_nxt = inv_found_r;
    inv_idx_nxt   = inv_idx_r;
    valid_nxt     = valid_r;
    meta_ok_nxt   = meta_ok_r;
    pend_nxt      = pend_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    emit_valid    = 1'b0;
    emit          = pend_r;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FN_LOOKUP: begin
              ram_re        = 1'b1;
              ram_raddr     = '0;
              cnt_nxt       = '0;
              tag_nxt       = TAG_BITS'(in_sector_number);
              inv_found_nxt = 1'b0;
              state_nxt     = S_SCAN;
            end
            FN_RELEASE: begin
              cnt_nxt  = IDX_W'(in_entry_index);
              pend_nxt = make_res(ST_REL_UNDER, SLOT_W'(in_entry_index), 1'b0, '0,
                                  1'b0, 1'b1);
              if (32'(in_entry_index) >= 32'(ENTRIES)) begin
                state_nxt = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(in_entry_index);
                state_nxt = S_REL;
              end
            end
            FN_FLUSH: begin
              cnt_nxt   = '0;
              state_nxt = S_FLUSH;
            end
            default: ;
          endcase
        end
      end

      // Compare one entry per cycle while the next read is in flight.
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = idx_next(cnt_r);
        cnt_nxt   = idx_next(cnt_r);
        if (valid_r[cnt_r] && rd_tag == tag_r) begin
          ram_we              = 1'b1;
          ram_waddr           = cnt_r;
          ram_wdata           = {rd_tag, pins_inc, rd_acc};
          meta_ok_nxt[cnt_r]  = 1'b1;
          pend_nxt  = make_res(ST_HIT, SLOT_W'(cnt_r), 1'b0, '0, 1'b0, 1'b1);
          state_nxt = S_RESP;
        end else begin
          if (!valid_r[cnt_r] && !inv_found_r) begin
            inv_found_nxt = 1'b1;
            inv_idx_nxt   = cnt_r;
          end
          if (cnt_r == LAST_IDX) begin
            if (inv_found_r || !valid_r[cnt_r]) begin
              ram_we                = 1'b1;
              ram_waddr             = fill_idx;
              ram_wdata             = {tag_r, PIN_ONE, 1'b1};
              valid_nxt[fill_idx]   = 1'b1;
              meta_ok_nxt[fill_idx] = 1'b1;
              pend_nxt  = make_res(ST_FILL, SLOT_W'(fill_idx), 1'b0, '0, 1'b1, 1'b1);
              state_nxt = S_RESP;
            end else begin
              // Every entry is valid: start the clock sweep at the hand.
              ram_raddr = hand_r;
              step_nxt  = '0;
              state_nxt = S_SWEEP;
            end
          end
        end
      end

      // One sweep step per cycle; the read of the following entry overlaps.
      S_SWEEP: begin
        ram_re    = 1'b1;
        ram_raddr = idx_next(hand_r);
        if (rd_pins == '0 && !rd_acc) begin
          ram_we              = 1'b1;
          ram_waddr           = hand_r;
          ram_wdata           = {tag_r, PIN_ONE, 1'b1};
          meta_ok_nxt[hand_r] = 1'b1;
          pend_nxt  = make_res(ST_EVICT, SLOT_W'(hand_r), 1'b1, SECTOR_W'(rd_tag),
                               1'b1, 1'b1);
          state_nxt = S_RESP;
        end else begin
          // Unpinned entries get their second chance.
          if (rd_pins == '0) begin
            ram_we    = 1'b1;
            ram_waddr = hand_r;
            ram_wdata = {rd_tag, rd_pins, 1'b0};
          end
          hand_nxt = idx_next(hand_r);
          step_nxt = step_r + STEP_W'(1);
          if (step_r == STEP_LAST) begin
            pend_nxt  = make_res(ST_BUSY, '0, 1'b0, '0, 1'b0, 1'b1);
            state_nxt = S_RESP;
          end
        end
      end

      // Release: drop one pin unless the count is already zero.
      S_REL: begin
        if (rd_pins != '0) begin
          ram_we          = 1'b1;
          ram_waddr       = cnt_r;
          ram_wdata       = {rd_tag, rd_pins - PIN_ONE, rd_acc};
          pend_nxt.status = ST_RELEASED;
        end
        state_nxt = S_RESP;
      end

      // Flush: skip invalid entries, fetch the tag of valid ones.
      S_FLUSH: begin
        if (valid_r[cnt_r]) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r;
          state_nxt = S_FLRD;
        end else if (cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = idx_next(cnt_r);
        end
      end

      // Hand one flushed entry to the output stage; the RAM holds its data.
      S_FLRD: begin
        if (out_free) begin
          emit_valid = 1'b1;
          emit = make_res(ST_FLUSHED, SLOT_W'(cnt_r), 1'b1, SECTOR_W'(rd_tag), 1'b0,
                          ~|(valid_r & ~(ENTRIES'(1) << cnt_r)));
          valid_nxt[cnt_r] = 1'b0;
          if (cnt_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = idx_next(cnt_r);
            state_nxt = S_FLUSH;
          end
        end
      end

      // Single-result transactions leave through here.
      S_RESP: begin
        if (out_free) begin
          emit_valid = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> design/sct_out_stage.sv
// Output register that holds one result until the sink takes it.
module sct_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          emit_valid,
  input  sct_pkg::res_t emit,
  output logic          free,
  sct_out_if.source     out_ch
);
  import sct_pkg::*;

  logic out_valid_r;
  res_t res_r;

  // The stage can load whenever it is empty or its content leaves now.
  assign free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (free) begin
      out_valid_r <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && emit_valid) begin
      res_r <= emit;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = res_r.status;
  assign out_ch.slot             = res_r.slot;
  assign out_ch.writeback        = res_r.writeback;
  assign out_ch.writeback_sector = res_r.writeback_sector;
  assign out_ch.fetch            = res_r.fetch;
  assign out_ch.last             = res_r.last;

endmodule
